// ===== hw/rtl/lkbs_pkg.sv =====
// lkbs_pkg: sizes, action codes and the command/status structs of the
// keyed block store. No dependencies; every other file imports it.
package lkbs_pkg;

    localparam int ENTRIES   = 128;
    localparam int KEY_BITS  = 64;
    localparam int DATA_BITS = 64;

    // fixed widths of the item fields and the capacity register
    localparam int FIELD_W  = 64;
    localparam int ACTION_W = 2;
    localparam int CAP_W    = 8;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int AGE_W = IDX_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

    // action codes; every other code behaves as a presence query
    localparam logic [ACTION_W-1:0] ACT_INSERT = ACTION_W'(1);
    localparam logic [ACTION_W-1:0] ACT_READ   = ACTION_W'(2);

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic update;
        logic emit;
    } lkbs_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic out_free;
    } lkbs_stat_t;

endpackage

// ===== hw/rtl/lkbs_if.sv =====
// lkbs_req_if / lkbs_rsp_if: valid/ready channels for request and result items.
// Depends on lkbs_pkg for the field widths.
interface lkbs_req_if import lkbs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [FIELD_W-1:0]  key;
    logic [FIELD_W-1:0]  write_data;

    modport source (output valid, output action, output key, output write_data, input ready);
    modport sink   (input valid, input action, input key, input write_data, output ready);
endinterface

interface lkbs_rsp_if import lkbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] read_data;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;

    modport source (output valid, output hit, output read_data, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_data, input evicted,
                    input evicted_key, output ready);
endinterface

// ===== hw/rtl/lkbs_ctrl.sv =====
// lkbs_ctrl: sequencer for one item: scan sweep, decision, age sweep, result.
// Depends on lkbs_pkg for the command and status structs.
module lkbs_ctrl import lkbs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lkbs_stat_t stat,
    output lkbs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_comb
    begin
        cmd.load   = in_valid && ready_reg;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.decide = (state_reg == S_DECIDE);
        cmd.update = (state_reg == S_UPDATE);
        cmd.emit   = (state_reg == S_EMIT) && stat.out_free;
    end

    assign in_ready = ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        state_reg <= S_SCAN;
                        ready_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (stat.sweep_done)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (stat.sweep_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lkbs_datapath.sv =====
// lkbs_datapath: entry memories, valid bits, sweep counter, decision logic
// and the result register. Depends on lkbs_pkg.
module lkbs_datapath import lkbs_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  lkbs_cmd_t           cmd,
    output lkbs_stat_t          stat,
    input  logic [ACTION_W-1:0] in_action,
    input  logic [FIELD_W-1:0]  in_key,
    input  logic [FIELD_W-1:0]  in_write_data,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_hit,
    output logic [FIELD_W-1:0]  out_read_data,
    output logic                out_evicted,
    output logic [FIELD_W-1:0]  out_evicted_key
);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_RECENT,
        MODE_SHIFT
    } upd_mode_t;

    // entry store
    logic [KEY_BITS-1:0]  key_mem  [ENTRIES];
    logic [DATA_BITS-1:0] data_mem [ENTRIES];
    logic [AGE_W-1:0]     age_mem  [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CAP_W-1:0]     cap_reg;

    // item
    logic [ACTION_W-1:0]  act_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] wdata_reg;

    // sweep
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pidx_reg;
    logic [KEY_BITS-1:0]  key_rd_reg;
    logic [DATA_BITS-1:0] data_rd_reg;
    logic [AGE_W-1:0]     age_rd_reg;
    logic [IDX_W-1:0]     raddr;
    logic                 issue;

    // scan findings
    logic                 hit_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [AGE_W-1:0]     old_age_reg;
    logic [DATA_BITS-1:0] hit_data_reg;
    logic                 lru_found_reg;
    logic [IDX_W-1:0]     lru_slot_reg;
    logic [KEY_BITS-1:0]  lru_key_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_slot_reg;

    // decision and age pass
    upd_mode_t            mode_reg;
    logic [IDX_W-1:0]     tgt_reg;
    logic                 res_hit_reg;
    logic [DATA_BITS-1:0] res_data_reg;
    logic                 res_evicted_reg;
    logic [KEY_BITS-1:0]  res_evkey_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [FIELD_W-1:0]   out_read_data_reg;
    logic                 out_evicted_reg;
    logic [FIELD_W-1:0]   out_evicted_key_reg;

    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     eff_cap;
    logic [CMP_W-1:0]     count_ext;
    logic                 miss_ins;
    logic                 evict;
    logic                 place;
    logic [IDX_W-1:0]     new_slot;
    logic                 cur_valid;
    logic                 age_we;
    logic [AGE_W-1:0]     age_wdata;

    assign raddr = cnt_reg[IDX_W-1:0];
    assign issue = (cmd.scan || (cmd.update && (mode_reg != MODE_NONE)))
                   && (cnt_reg < CNT_W'(ENTRIES));
    assign cur_valid = valid_reg[pidx_reg];

    assign stat.sweep_done = !issue && !pend_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // capacity of zero acts as one, above the store size as the store size
    always_comb
    begin
        cap_ext   = CMP_W'(cap_reg);
        count_ext = CMP_W'(count_reg);
        if (cap_reg == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
        else
            eff_cap = cap_ext;

        miss_ins = (act_reg == ACT_INSERT) && !hit_reg;
        evict    = miss_ins && (count_ext >= eff_cap) && (count_reg != '0) && lru_found_reg;
        if (evict && !(free_found_reg && (free_slot_reg < lru_slot_reg)))
            new_slot = lru_slot_reg;
        else
            new_slot = free_slot_reg;
        place = miss_ins && (evict || free_found_reg);
    end

    // age rewrite during the second sweep
    always_comb
    begin
        age_we    = 1'b0;
        age_wdata = age_rd_reg + AGE_W'(1);
        if (cmd.update && pend_reg && cur_valid)
        begin
            case (mode_reg)
                MODE_RECENT:
                begin
                    if (pidx_reg == tgt_reg)
                    begin
                        age_we    = 1'b1;
                        age_wdata = '0;
                    end
                    else if (age_rd_reg < old_age_reg)
                        age_we = 1'b1;
                end
                MODE_SHIFT:
                begin
                    age_we = 1'b1;
                    if (pidx_reg == tgt_reg)
                        age_wdata = '0;
                end
                default:
                begin
                    age_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[raddr];
        data_rd_reg <= data_mem[raddr];
        age_rd_reg  <= age_mem[raddr];
        if (cmd.decide && place)
        begin
            key_mem[new_slot]  <= key_reg;
            data_mem[new_slot] <= wdata_reg;
        end
        if (age_we)
            age_mem[pidx_reg] <= age_wdata;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            cap_reg        <= CAP_RESET;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            mode_reg       <= MODE_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;

            // no read is issued in the load or decision cycle, so this
            // also clears the pending flag there
            pend_reg <= issue;
            if (issue)
                cnt_reg <= cnt_reg + CNT_W'(1);

            if (cmd.load)
            begin
                cnt_reg        <= '0;
                hit_reg        <= 1'b0;
                lru_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan && pend_reg)
            begin
                if (cur_valid && (key_rd_reg == key_reg))
                    hit_reg <= 1'b1;
                if (cur_valid && ((CNT_W'(age_rd_reg) + CNT_W'(1)) == count_reg))
                    lru_found_reg <= 1'b1;
                if (!cur_valid)
                    free_found_reg <= 1'b1;
            end

            if (cmd.decide)
            begin
                cnt_reg <= '0;
                // an evicted slot that takes the new key stays valid
                if (evict && (new_slot != lru_slot_reg))
                    valid_reg[lru_slot_reg] <= 1'b0;
                if (place)
                    valid_reg[new_slot] <= 1'b1;
                count_reg <= count_reg - CNT_W'(evict) + CNT_W'(place);
                if (hit_reg && ((act_reg == ACT_INSERT) || (act_reg == ACT_READ)))
                    mode_reg <= MODE_RECENT;
                else if (place)
                    mode_reg <= MODE_SHIFT;
                else
                    mode_reg <= MODE_NONE;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= in_action;
            key_reg   <= in_key[KEY_BITS-1:0];
            wdata_reg <= in_write_data[DATA_BITS-1:0];
        end

        if (issue)
            pidx_reg <= raddr;

        if (cmd.scan && pend_reg)
        begin
            if (cur_valid && (key_rd_reg == key_reg))
            begin
                slot_reg     <= pidx_reg;
                old_age_reg  <= age_rd_reg;
                hit_data_reg <= data_rd_reg;
            end
            if (cur_valid && ((CNT_W'(age_rd_reg) + CNT_W'(1)) == count_reg))
            begin
                lru_slot_reg <= pidx_reg;
                lru_key_reg  <= key_rd_reg;
            end
            if (!cur_valid && !free_found_reg)
                free_slot_reg <= pidx_reg;
        end

        if (cmd.decide)
        begin
            tgt_reg         <= hit_reg ? slot_reg : new_slot;
            res_hit_reg     <= hit_reg;
            res_data_reg    <= (hit_reg && (act_reg == ACT_READ)) ? hit_data_reg : '0;
            res_evicted_reg <= evict;
            res_evkey_reg   <= evict ? lru_key_reg : '0;
        end

        if (cmd.emit)
        begin
            out_hit_reg         <= res_hit_reg;
            out_read_data_reg   <= FIELD_W'(res_data_reg);
            out_evicted_reg     <= res_evicted_reg;
            out_evicted_key_reg <= FIELD_W'(res_evkey_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_read_data   = out_read_data_reg;
    assign out_evicted     = out_evicted_reg;
    assign out_evicted_key = out_evicted_key_reg;

endmodule

// ===== hw/rtl/lru_keyed_block_store.sv =====
// Fully associative key/data store with least-recently-used replacement.
// One item is in work at a time: the next is taken once the last result enters the
// result register. Each item runs a key match scan and an age rewrite sweep through one
// read port; a query, the spare code or a read miss skips the age sweep.
// Reset: valid bits and entry count clear at once, capacity returns to 128; no clearing pass.
module lru_keyed_block_store import lkbs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    lkbs_req_if.sink         req,
    lkbs_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    lkbs_cmd_t  cmd;
    lkbs_stat_t stat;

    // Sequencer: takes one item, steps the datapath through the scan sweep,
    // the decision cycle and the age sweep, then hands the result over.
    lkbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: key, data and age memories with valid bits in flip-flops.
    // The scan finds the matching entry, the least recent entry (age equal
    // to count minus one) and the first free slot; the decision cycle
    // evicts, writes the new key and data and picks the age rewrite; the
    // result register lets the next item in while a result waits.
    lkbs_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_action       (req.action),
        .in_key          (req.key),
        .in_write_data   (req.write_data),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_hit         (rsp.hit),
        .out_read_data   (rsp.read_data),
        .out_evicted     (rsp.evicted),
        .out_evicted_key (rsp.evicted_key)
    );

endmodule

// ===== hw/rtl/lkbs_checker.sv =====
// lkbs_checker: port-level assertions for the keyed block store, and the
// bind that attaches them to the top level. Depends on lkbs_pkg.
module lkbs_checker import lkbs_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_hit,
    input logic [FIELD_W-1:0] rsp_read_data,
    input logic               rsp_evicted,
    input logic [FIELD_W-1:0] rsp_evicted_key
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
        && $stable(rsp_evicted_key) && $stable(rsp_hit) && $stable(rsp_evicted))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while another is in work");

    // eviction only on a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_evicted |-> !rsp_hit)
        else $error("eviction reported on a hit");

    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
        else $error("evicted key without eviction");

    a_data_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_read_data != '0) |-> rsp_hit)
        else $error("read data on a miss");

endmodule

bind lru_keyed_block_store lkbs_checker u_lkbs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_read_data   (rsp.read_data),
    .rsp_evicted     (rsp.evicted),
    .rsp_evicted_key (rsp.evicted_key)
);

// ===== verif/tb_lru_keyed_block_store.sv =====
// Testbench for lru_keyed_block_store: directed and random request items checked
// against an in-bench prediction of the LRU store. Depends on lkbs_pkg and lkbs_if.
module tb_lru_keyed_block_store;
    import lkbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves implicit: a plain presence query and the spare code.
    localparam logic [ACTION_W-1:0] ACT_QUERY = ACTION_W'(0);
    localparam logic [ACTION_W-1:0] ACT_SPARE = ACTION_W'(3);

    localparam logic [FIELD_W-1:0] KEY_MASK  = {FIELD_W{1'b1}} >> (FIELD_W - KEY_BITS);
    localparam logic [FIELD_W-1:0] DATA_MASK = {FIELD_W{1'b1}} >> (FIELD_W - DATA_BITS);
    localparam logic [FIELD_W-1:0] ALL_ONES  = {FIELD_W{1'b1}};

    // The long hold-off dwarfs the time one item takes, and the watchdog allows several
    // times the worst quiet spell.
    localparam int PRESSURE_CYCLES = 1500;
    localparam int STALL_LIMIT     = 8000;
    localparam int TAIL_CYCLES     = 2 * ENTRIES + 40;
    localparam int POOL_SIZE       = 256;

    typedef struct {
        logic               hit;
        logic [FIELD_W-1:0] read_data;
        logic               evicted;
        logic [FIELD_W-1:0] evicted_key;
    } store_result_t;

    // Shadow copy of the store: works out the result of every accepted request
    // item and holds the results still owed by the block, oldest first.
    class store_tracker;
        bit                 slot_used[ENTRIES];
        logic [FIELD_W-1:0] slot_key[ENTRIES];
        logic [FIELD_W-1:0] slot_data[ENTRIES];
        int unsigned        slot_age[ENTRIES];
        int unsigned        used_count;
        logic [CAP_W-1:0]   capacity;
        store_result_t      awaited[$];
        int unsigned        failures;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_data[i] = '0;
                slot_age[i]  = 0;
            end
            used_count = 0;
            capacity   = CAP_RESET;
            failures   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned waiting();
            return awaited.size();
        endfunction

        function int find_key(logic [FIELD_W-1:0] k);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_key[i] == k)
                    return i;
            return -1;
        endfunction

        // age every entry more recent than slot s, then make s the most recent
        function void promote(int s);
            int unsigned old_age;
            old_age = slot_age[s];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i] && slot_age[i] < old_age)
                    slot_age[i]++;
            slot_age[s] = 0;
        endfunction

        function int unsigned cap_limit();
            int unsigned c;
            c = capacity;
            if (c == 0)
                c = 1;
            if (c > ENTRIES)
                c = ENTRIES;
            return c;
        endfunction

        function void note_item(logic [ACTION_W-1:0] act, logic [FIELD_W-1:0] key_in,
                                logic [FIELD_W-1:0] data_in);
            store_result_t      r;
            logic [FIELD_W-1:0] k;
            logic [FIELD_W-1:0] d;
            int                 s;
            int                 lru;
            int                 fr;
            k = key_in & KEY_MASK;
            d = data_in & DATA_MASK;
            r.hit         = 1'b0;
            r.read_data   = '0;
            r.evicted     = 1'b0;
            r.evicted_key = '0;
            s = find_key(k);
            if (s >= 0)
                r.hit = 1'b1;
            if (act == ACT_INSERT)
            begin
                if (s >= 0)
                    promote(s);
                else
                begin
                    if (used_count >= cap_limit() && used_count > 0)
                    begin
                        lru = -1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_used[i] && (lru < 0 || slot_age[i] > slot_age[lru]))
                                lru = i;
                        if (lru >= 0)
                        begin
                            r.evicted      = 1'b1;
                            r.evicted_key  = slot_key[lru];
                            slot_used[lru] = 1'b0;
                            used_count--;
                        end
                    end
                    fr = -1;
                    for (int i = 0; i < ENTRIES && fr < 0; i++)
                        if (!slot_used[i])
                            fr = i;
                    if (fr >= 0)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_used[i])
                                slot_age[i]++;
                        slot_used[fr] = 1'b1;
                        slot_key[fr]  = k;
                        slot_data[fr] = d;
                        slot_age[fr]  = 0;
                        used_count++;
                    end
                end
            end
            else if (act == ACT_READ)
            begin
                if (s >= 0)
                begin
                    r.read_data = slot_data[s];
                    promote(s);
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_item(store_result_t got);
            store_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result item with nothing outstanding: hit %0d read_data %h",
                       got.hit, got.read_data);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                failures++;
            end
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
                failures++;
            end
            if (got.evicted !== want.evicted)
            begin
                $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
                failures++;
            end
            if (got.evicted_key !== want.evicted_key)
            begin
                $error("evicted_key: expected %h, actual %h", want.evicted_key,
                       got.evicted_key);
                failures++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    lkbs_req_if req_ch ();
    lkbs_rsp_if rsp_ch ();

    lru_keyed_block_store DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    store_tracker       tracker;
    bit                 steady_flow;   // no idling on either side while set
    bit                 pressure_req;  // ask the receiver for one long hold-off
    logic [FIELD_W-1:0] key_pool[POOL_SIZE];

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; none at all in steady stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offer one request item after any idle gap drawn and hold it until it is taken.
    // Entered and left just after a rising edge.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [FIELD_W-1:0] k,
                             logic [FIELD_W-1:0] d);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid      = 1'b1;
        req_ch.action     = act;
        req_ch.key        = k;
        req_ch.write_data = d;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_item(act, k, d);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (tracker.waiting() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        tracker.set_capacity(value);
        @(negedge clk);
        cfg_we = 1'b0;
        @(posedge clk);
    endtask

    // Pull a key from a window of the shared pool so that earlier entries keep
    // being hit; a few keys are fresh words or the extremes.
    function automatic logic [FIELD_W-1:0] pick_key(int unsigned base, int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return '0;
        if (r < 4)
            return ALL_ONES;
        if (r < 12)
            return rand_word();
        return key_pool[base + $urandom_range(0, span - 1)];
    endfunction

    task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned n_items,
                             int unsigned insert_pct, bit steady, bit squeeze);
        int unsigned        span;
        int unsigned        base;
        int unsigned        eff;
        int unsigned        r;
        logic [ACTION_W-1:0] act;
        write_capacity(cap);
        eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
        span = eff + eff / 2 + 2;
        if (span > POOL_SIZE)
            span = POOL_SIZE;
        base = $urandom_range(0, POOL_SIZE - span);
        steady_flow = steady;
        if (squeeze)
            pressure_req = 1'b1;
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                act = ACT_INSERT;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    act = ACT_READ;
                else if (r < 85)
                    act = ACT_QUERY;
                else
                    act = ACT_SPARE;
            end
            send_item(act, pick_key(base, span), rand_word());
        end
        steady_flow = 1'b0;
    endtask

    // Receiver: stall for a random spell after each result item, or for one long
    // stretch on request while the sender keeps offering, so the block backs up.
    initial
    begin : result_sink
        int unsigned   hold_left;
        store_result_t got;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_req)
            begin
                pressure_req = 1'b0;
                hold_left    = PRESSURE_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready = 1'b1;
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.hit         = rsp_ch.hit;
                got.read_data   = rsp_ch.read_data;
                got.evicted     = rsp_ch.evicted;
                got.evicted_key = rsp_ch.evicted_key;
                tracker.check_item(got);
                hold_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run when no item moves on either channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("lru_keyed_block_store: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        tracker      = new();
        steady_flow  = 1'b0;
        pressure_req = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = rand_word();

        // drive every input to a known value before reset lifts
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_QUERY;
        req_ch.key        = '0;
        req_ch.write_data = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Two entries: misses on an empty store, extreme keys and data, an
        // insert of a present key that must keep its old data, a read that
        // saves its entry from eviction, and the spare code acting as a query.
        write_capacity(CAP_W'(2));
        send_item(ACT_QUERY, '0, '0);
        send_item(ACT_READ, ALL_ONES, ALL_ONES);
        send_item(ACT_INSERT, '0, ALL_ONES);
        send_item(ACT_INSERT, ALL_ONES, '0);
        send_item(ACT_INSERT, '0, 64'h0000_0000_0000_1234);
        send_item(ACT_READ, '0, '0);
        send_item(ACT_SPARE, ALL_ONES, ALL_ONES);
        send_item(ACT_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ACT_READ, ALL_ONES, '0);
        send_item(ACT_QUERY, 64'h5555_5555_5555_5555, ALL_ONES);
        send_item(ACT_READ, 64'h5555_5555_5555_5555, '0);

        // Capacity zero acts as one, and now sits below the count: each new
        // key evicts exactly one entry and the count holds at two.
        write_capacity(CAP_W'(0));
        send_item(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_item(ACT_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_item(ACT_READ, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_item(ACT_INSERT, 64'h0123_4567_89AB_CDEF, '0);
        send_item(ACT_QUERY, '0, '0);

        // Capacity above the entry count saturates.
        write_capacity(ALL_ONES[CAP_W-1:0]);
        send_item(ACT_INSERT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_item(ACT_INSERT, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
        send_item(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES);
        send_item(ACT_READ, 64'h8000_0000_0000_0000, '0);
        send_item(ACT_SPARE, 64'h0000_0000_0000_0001, '0);
        send_item(ACT_READ, 64'h7FFF_FFFF_FFFF_FFFF, '0);

        // Random phases: capacity, item count, share of inserts, steady flow,
        // long receiver hold-off. The full-size phases fill the store so the
        // later small capacities start well below the count.
        run_phase(CAP_W'(16), 170, 45, 1'b0, 1'b0);
        run_phase(CAP_W'(1), 120, 50, 1'b0, 1'b0);
        run_phase(CAP_W'(0), 80, 50, 1'b1, 1'b0);
        run_phase(CAP_RESET, 230, 75, 1'b0, 1'b1);
        run_phase(CAP_RESET, 180, 45, 1'b0, 1'b0);
        run_phase(ALL_ONES[CAP_W-1:0], 150, 55, 1'b1, 1'b0);
        run_phase(CAP_W'(4), 150, 45, 1'b0, 1'b0);
        run_phase(CAP_W'($urandom_range(0, 255)), 150, 45, 1'b0, 1'b0);
        run_phase(CAP_W'(2), 120, 50, 1'b0, 1'b1);
        run_phase(CAP_W'(64), 170, 50, 1'b0, 1'b0);
        run_phase(CAP_W'($urandom_range(1, 127)), 150, 45, 1'b0, 1'b0);
        run_phase(CAP_RESET, 130, 60, 1'b1, 1'b0);

        // wait out the last results, then a little over one item's latency
        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (tracker.waiting() != 0)
            $error("%0d result items never arrived", tracker.waiting());
        if (tracker.failures == 0 && tracker.waiting() == 0)
            $display("lru_keyed_block_store: match");
        else
            $display("lru_keyed_block_store: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lkbs_pkg.sv
hw/rtl/lkbs_if.sv
hw/rtl/lkbs_ctrl.sv
hw/rtl/lkbs_datapath.sv
hw/rtl/lru_keyed_block_store.sv
hw/rtl/lkbs_checker.sv
verif/tb_lru_keyed_block_store.sv
